// ===== src/speaker_layout_mixer_unit_assert.svh =====
// assertion macros shared by the speaker layout mixer rtl
// expects signals named clk and rst_n in the including module
`ifndef SPEAKER_LAYOUT_MIXER_UNIT_ASSERT_SVH
`define SPEAKER_LAYOUT_MIXER_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define SLM_ASSERT_IMPLY(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("slm assertion failed");
`define SLM_ASSERT_NEXT(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("slm assertion failed");
`else
`define SLM_ASSERT_IMPLY(label, cond, prop)
`define SLM_ASSERT_NEXT(label, cond, prop)
`endif
`endif

// ===== src/slm_pkg.sv =====
// shared types, constants and weight table for the speaker layout mixer
// no dependencies
package slm_pkg;

    localparam int MAX_CHANNELS = 6;
    localparam int SAMPLE_BITS  = 24;
    localparam int CNT_W        = 3;
    localparam int CFG_INDEX_W  = 2;
    localparam int FRAC_BITS    = 16;
    localparam int WEIGHT_W     = 17;
    localparam int PROD_W       = SAMPLE_BITS + WEIGHT_W + 1;
    localparam int SUM_W        = SAMPLE_BITS + FRAC_BITS + 4;
    localparam int HALF_LANES   = MAX_CHANNELS / 2;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [PROD_W-1:0]      prod_t;
    typedef logic signed [SUM_W-1:0]       sum_t;
    typedef logic [CNT_W-1:0]              count_t;
    typedef logic [CFG_INDEX_W-1:0]        cfg_index_t;

    // register indexes on the configuration channel
    localparam cfg_index_t CFG_SOURCE_CHANNELS = cfg_index_t'(0);
    localparam cfg_index_t CFG_DEST_CHANNELS   = cfg_index_t'(1);
    localparam count_t     CNT_RESET           = count_t'(2);

    // sqrt(1/2) in q0.16, with a zero sign bit for signed multiply
    localparam logic signed [WEIGHT_W:0] RHALF_S = (WEIGHT_W+1)'(46341);
    localparam sum_t ROUND_HALF = sum_t'(1) <<< (FRAC_BITS - 1);
    localparam sample_t SAT_HI = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam sample_t SAT_LO = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    typedef enum logic [2:0] {
        W_ZERO,
        W_QUARTER,
        W_HALF,
        W_RHALF,
        W_ONE
    } weight_t;

    typedef struct packed {
        logic en_c;
        logic en_d;
    } slm_ctl_t;

    // zero counts as mono, anything above the lane count as full layout
    function automatic count_t clamp_count(input count_t v);
        count_t r;
        r = v;
        if (v == count_t'(0))
            r = count_t'(1);
        else if (int'(v) > MAX_CHANNELS)
            r = count_t'(MAX_CHANNELS);
        return r;
    endfunction

    // weight of source channel j into destination channel i
    function automatic weight_t weight_code(input count_t s, input count_t d,
                                            input int i, input int j);
        weight_t w;
        count_t  n;
        w = W_ZERO;
        n = (s < d) ? s : d;
        case ({s, d})
            {3'd1, 3'd2}, {3'd1, 3'd4}:
            begin
                if (j == 0 && (i == 0 || i == 1)) w = W_ONE;
            end
            {3'd1, 3'd6}:
            begin
                if (i == 2 && j == 0) w = W_ONE;
            end
            {3'd2, 3'd4}, {3'd2, 3'd6}:
            begin
                if (i == j && i < 2) w = W_ONE;
            end
            {3'd4, 3'd6}:
            begin
                if ((i == 0 && j == 0) || (i == 1 && j == 1) ||
                    (i == 4 && j == 2) || (i == 5 && j == 3)) w = W_ONE;
            end
            {3'd2, 3'd1}:
            begin
                if (i == 0 && j < 2) w = W_HALF;
            end
            {3'd4, 3'd1}:
            begin
                if (i == 0 && j < 4) w = W_QUARTER;
            end
            {3'd6, 3'd1}:
            begin
                if (i == 0) begin
                    if (j == 0 || j == 1) w = W_RHALF;
                    else if (j == 2) w = W_ONE;
                    else if (j == 4 || j == 5) w = W_HALF;
                end
            end
            {3'd4, 3'd2}:
            begin
                if ((i == 0 && (j == 0 || j == 2)) || (i == 1 && (j == 1 || j == 3)))
                    w = W_HALF;
            end
            {3'd6, 3'd2}:
            begin
                if (i == 0) begin
                    if (j == 0) w = W_ONE;
                    else if (j == 2 || j == 4) w = W_RHALF;
                end else if (i == 1) begin
                    if (j == 1) w = W_ONE;
                    else if (j == 2 || j == 5) w = W_RHALF;
                end
            end
            {3'd6, 3'd4}:
            begin
                if (i == 0) begin
                    if (j == 0) w = W_ONE;
                    else if (j == 2) w = W_RHALF;
                end else if (i == 1) begin
                    if (j == 1) w = W_ONE;
                    else if (j == 2) w = W_RHALF;
                end else if (i == 2 && j == 4) w = W_ONE;
                else if (i == 3 && j == 5) w = W_ONE;
            end
            default:
            begin
                // equal counts and pairs without a speaker rule
                if (i == j && i < int'(n)) w = W_ONE;
            end
        endcase
        return w;
    endfunction

endpackage

// ===== src/slm_in_if.sv =====
// frame input channel: six source and six destination samples
// depends on slm_pkg
interface slm_in_if;
    import slm_pkg::*;

    logic    valid;
    logic    ready;
    sample_t src_0, src_1, src_2, src_3, src_4, src_5;
    sample_t acc_0, acc_1, acc_2, acc_3, acc_4, acc_5;

    modport source (output valid, src_0, src_1, src_2, src_3, src_4, src_5,
                    acc_0, acc_1, acc_2, acc_3, acc_4, acc_5, input ready);
    modport sink   (input valid, src_0, src_1, src_2, src_3, src_4, src_5,
                    acc_0, acc_1, acc_2, acc_3, acc_4, acc_5, output ready);
endinterface

// ===== src/slm_out_if.sv =====
// mixed frame output channel with clip flag
// depends on slm_pkg
interface slm_out_if;
    import slm_pkg::*;

    logic    valid;
    logic    ready;
    sample_t mix_0, mix_1, mix_2, mix_3, mix_4, mix_5;
    logic    clipped;

    modport source (output valid, mix_0, mix_1, mix_2, mix_3, mix_4, mix_5,
                    clipped, input ready);
    modport sink   (input valid, mix_0, mix_1, mix_2, mix_3, mix_4, mix_5,
                    clipped, output ready);
endinterface

// ===== src/slm_cfg_if.sv =====
// configuration write channel: register index and write data
// depends on slm_pkg
interface slm_cfg_if;
    import slm_pkg::*;

    logic       valid;
    logic       ready;
    cfg_index_t index;
    count_t     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/speaker_layout_mixer_unit.sv =====
// speaker layout mixer top level: config registers, pipeline control, lanes
// depends on slm_pkg, slm_in_if, slm_out_if, slm_cfg_if, slm_mix_lane
//
// usage:
//   frames carries one audio frame per transfer: six source samples src_*
//   and six destination samples acc_*, signed q1.23. mixes returns one
//   mixed frame per input frame, in order, with a clip flag that is set when
//   any active destination channel saturated. cfg writes source_channels
//   (index 0) and dest_channels (index 1); it is always ready, and writes
//   belong to times when no frame is in flight. other indexes are ignored.
// timing:
//   four register stages (capture, sqrt(1/2) multiply, partial sums,
//   round and saturate): a frame passes through them in that order before
//   it shows on mixes. one frame per cycle is sustained while mixes is
//   ready; the only multiplier is one 24x18 product per source channel in
//   the second stage.
// reset and stall:
//   reset empties the pipeline and sets both channel counts to stereo.
//   when mixes is stalled, frames keep flowing into empty stages until the
//   pipeline is full; then frames.ready drops. nothing is lost or repeated.
module speaker_layout_mixer_unit (
    input logic        clk,
    input logic        rst_n,
    slm_in_if.sink     frames,
    slm_out_if.source  mixes,
    slm_cfg_if.sink    cfg
);
    import slm_pkg::*;

    `include "speaker_layout_mixer_unit_assert.svh"

    count_t    src_cnt_reg;
    count_t    dst_cnt_reg;
    count_t    s_eff;
    count_t    d_eff;
    weight_t   codes [MAX_CHANNELS][MAX_CHANNELS];

    logic      v_a_reg, v_b_reg, v_c_reg, v_d_reg;
    logic      en_a, en_b;
    slm_ctl_t  ctl;

    sample_t   in_src [MAX_CHANNELS];
    sample_t   in_acc [MAX_CHANNELS];
    sample_t   src_a_reg [MAX_CHANNELS];
    sample_t   acc_a_reg [MAX_CHANNELS];
    sample_t   src_b_reg [MAX_CHANNELS];
    sample_t   acc_b_reg [MAX_CHANNELS];
    prod_t     prod_b_reg [MAX_CHANNELS];
    sample_t   mix [MAX_CHANNELS];
    logic      clip [MAX_CHANNELS];
    logic      clip_any;

    logic      in_xfer;
    logic      out_xfer;
    logic [2:0] occupancy;
    logic      rail_hit;

    // configuration register writes
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            src_cnt_reg <= CNT_RESET;
            dst_cnt_reg <= CNT_RESET;
        end else if (cfg.valid && cfg.ready) begin
            case (cfg.index)
                CFG_SOURCE_CHANNELS: src_cnt_reg <= cfg.data;
                CFG_DEST_CHANNELS:   dst_cnt_reg <= cfg.data;
                default:             ;
            endcase
        end
    end

    // weight selection; the user must keep the counts stable while frames are in flight, the block does not enforce it
    assign s_eff = clamp_count(src_cnt_reg);
    assign d_eff = clamp_count(dst_cnt_reg);

    always_comb
    begin
        for (int i = 0; i < MAX_CHANNELS; i++)
            for (int j = 0; j < MAX_CHANNELS; j++)
                codes[i][j] = weight_code(s_eff, d_eff, i, j);
    end

    // stage enables: a stage moves when its successor is empty or moving
    assign ctl.en_d   = !v_d_reg || mixes.ready;
    assign ctl.en_c   = !v_c_reg || ctl.en_d;
    assign en_b       = !v_b_reg || ctl.en_c;
    assign en_a       = !v_a_reg || en_b;
    assign frames.ready = en_a;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            v_a_reg <= 1'b0;
            v_b_reg <= 1'b0;
            v_c_reg <= 1'b0;
            v_d_reg <= 1'b0;
        end else begin
            if (en_a)     v_a_reg <= frames.valid;
            if (en_b)     v_b_reg <= v_a_reg;
            if (ctl.en_c) v_c_reg <= v_b_reg;
            if (ctl.en_d) v_d_reg <= v_c_reg;
        end
    end

    // input payload as arrays
    assign in_src[0] = frames.src_0;
    assign in_src[1] = frames.src_1;
    assign in_src[2] = frames.src_2;
    assign in_src[3] = frames.src_3;
    assign in_src[4] = frames.src_4;
    assign in_src[5] = frames.src_5;
    assign in_acc[0] = frames.acc_0;
    assign in_acc[1] = frames.acc_1;
    assign in_acc[2] = frames.acc_2;
    assign in_acc[3] = frames.acc_3;
    assign in_acc[4] = frames.acc_4;
    assign in_acc[5] = frames.acc_5;

    // stage a: capture, unused source channels forced to zero
    always_ff @(posedge clk)
    begin
        if (en_a) begin
            for (int j = 0; j < MAX_CHANNELS; j++) begin
                src_a_reg[j] <= (j < int'(s_eff)) ? in_src[j] : '0;
                acc_a_reg[j] <= in_acc[j];
            end
        end
    end

    // stage b: sqrt(1/2) products
    always_ff @(posedge clk)
    begin
        if (en_b) begin
            for (int j = 0; j < MAX_CHANNELS; j++) begin
                prod_b_reg[j] <= src_a_reg[j] * RHALF_S;
                src_b_reg[j]  <= src_a_reg[j];
                acc_b_reg[j]  <= acc_a_reg[j];
            end
        end
    end

    // stages c and d: one lane per destination channel
    for (genvar i = 0; i < MAX_CHANNELS; i++) begin : g_lane
        slm_mix_lane u_lane (
            .clk    (clk),
            .ctl    (ctl),
            .src    (src_b_reg),
            .prod   (prod_b_reg),
            .codes  (codes[i]),
            .acc    (acc_b_reg[i]),
            .active (i < int'(d_eff)),
            .mix    (mix[i]),
            .clip   (clip[i])
        );
    end

    always_comb
    begin
        clip_any = 1'b0;
        for (int i = 0; i < MAX_CHANNELS; i++)
            clip_any = clip_any | clip[i];
    end

    // output payload
    assign mixes.valid   = v_d_reg;
    assign mixes.mix_0   = mix[0];
    assign mixes.mix_1   = mix[1];
    assign mixes.mix_2   = mix[2];
    assign mixes.mix_3   = mix[3];
    assign mixes.mix_4   = mix[4];
    assign mixes.mix_5   = mix[5];
    assign mixes.clipped = clip_any;

    // helpers for the checks below
    assign in_xfer   = frames.valid && frames.ready;
    assign out_xfer  = mixes.valid && mixes.ready;
    assign occupancy = 3'(v_a_reg) + 3'(v_b_reg) + 3'(v_c_reg) + 3'(v_d_reg);

    always_comb
    begin
        rail_hit = 1'b0;
        for (int i = 0; i < MAX_CHANNELS; i++)
            rail_hit = rail_hit | (mix[i] == SAT_HI) | (mix[i] == SAT_LO);
    end

    // input is refused only when the capture stage holds a frame
    `SLM_ASSERT_IMPLY(a_ready_full, !frames.ready, v_a_reg)

    // a frame in without a frame out adds exactly one to the occupancy
    `SLM_ASSERT_NEXT(a_occupancy, in_xfer && !out_xfer, occupancy == $past(occupancy) + 3'd1)

    // a clip flag comes with at least one rail value
    `SLM_ASSERT_IMPLY(a_clip_rail, mixes.valid && mixes.clipped, rail_hit)

endmodule

// ===== src/slm_mix_lane.sv =====
// one destination channel: weighted sum, rounding and saturation (stages c, d)
// depends on slm_pkg
module slm_mix_lane (
    input  logic               clk,
    input  slm_pkg::slm_ctl_t  ctl,
    input  slm_pkg::sample_t   src   [slm_pkg::MAX_CHANNELS],
    input  slm_pkg::prod_t     prod  [slm_pkg::MAX_CHANNELS],
    input  slm_pkg::weight_t   codes [slm_pkg::MAX_CHANNELS],
    input  slm_pkg::sample_t   acc,
    input  logic               active,
    output slm_pkg::sample_t   mix,
    output logic               clip
);
    import slm_pkg::*;

    sum_t    term [MAX_CHANNELS];
    sum_t    part0_reg, part0_next;
    sum_t    part1_reg, part1_next;
    sample_t acc_reg;
    logic    active_reg;
    sample_t mix_reg, mix_next;
    logic    clip_reg, clip_next;
    sum_t    total;
    sum_t    quot;

    // weighted terms: shifts for the power-of-two weights
    always_comb
    begin
        for (int j = 0; j < MAX_CHANNELS; j++) begin
            case (codes[j])
                W_ZERO:    term[j] = '0;
                W_QUARTER: term[j] = sum_t'(src[j]) <<< (FRAC_BITS - 2);
                W_HALF:    term[j] = sum_t'(src[j]) <<< (FRAC_BITS - 1);
                W_RHALF:   term[j] = sum_t'(prod[j]);
                W_ONE:     term[j] = sum_t'(src[j]) <<< FRAC_BITS;
                default:   term[j] = '0;
            endcase
        end
    end

    // stage c: two partial sums
    always_comb
    begin
        part0_next = sum_t'(acc) <<< FRAC_BITS;
        part1_next = '0;
        for (int j = 0; j < MAX_CHANNELS; j++) begin
            if (j < HALF_LANES)
                part0_next = part0_next + term[j];
            else
                part1_next = part1_next + term[j];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en_c) begin
            part0_reg  <= part0_next;
            part1_reg  <= part1_next;
            acc_reg    <= acc;
            active_reg <= active;
        end
    end

    // stage d: round half up, floor shift, saturate; inactive channels pass acc through
    always_comb
    begin
        total     = part0_reg + part1_reg + ROUND_HALF;
        quot      = total >>> FRAC_BITS;
        mix_next  = acc_reg;
        clip_next = 1'b0;
        if (active_reg) begin
            if (quot > sum_t'(SAT_HI)) begin
                mix_next  = SAT_HI;
                clip_next = 1'b1;
            end else if (quot < sum_t'(SAT_LO)) begin
                mix_next  = SAT_LO;
                clip_next = 1'b1;
            end else begin
                mix_next  = quot[SAMPLE_BITS-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en_d) begin
            mix_reg  <= mix_next;
            clip_reg <= clip_next;
        end
    end

    assign mix  = mix_reg;
    assign clip = clip_reg;

endmodule

// ===== sim/speaker_layout_mixer_unit_tb.sv =====
// self-checking testbench for speaker_layout_mixer_unit: directed layout cases, then
// random frames over every channel-count setting, checked against a behavioral mixer
// depends on slm_pkg, slm_in_if, slm_out_if, slm_cfg_if and the mixer rtl
module speaker_layout_mixer_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import slm_pkg::*;

    localparam int PIPE_DEPTH   = 4;
    localparam int HOLD_CYCLES  = 80;
    localparam int CYCLE_LIMIT  = 400000;

    // q1.16 speaker gains
    localparam longint GAIN_UNITY   = 65536;
    localparam longint GAIN_HALF    = 32768;
    localparam longint GAIN_QUARTER = 16384;
    localparam longint GAIN_RSQRT2  = 46341;

    // register indexes with nothing behind them
    localparam cfg_index_t CFG_UNMAPPED_LO = cfg_index_t'(2);
    localparam cfg_index_t CFG_UNMAPPED_HI = cfg_index_t'(3);

    typedef struct packed {
        logic [MAX_CHANNELS-1:0][SAMPLE_BITS-1:0] src;
        logic [MAX_CHANNELS-1:0][SAMPLE_BITS-1:0] acc;
    } frame_t;

    typedef struct packed {
        logic [MAX_CHANNELS-1:0][SAMPLE_BITS-1:0] mix;
        logic                                     clipped;
    } mixed_t;

    logic clk;
    logic rst_n;

    slm_in_if  frames_if ();
    slm_out_if mixes_if ();
    slm_cfg_if cfg_if ();

    speaker_layout_mixer_unit u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .frames (frames_if),
        .mixes  (mixes_if),
        .cfg    (cfg_if)
    );

    // layout registers as the mixer should hold them
    count_t src_count_reg;
    count_t dst_count_reg;

    mixed_t expected_mixes [$];
    int     mismatch_count;
    int     frames_sent;
    int     frames_checked;
    int     clipped_seen;
    int     input_stall_cycles;
    int     layouts_tried;
    int     cycle_count;

    bit     sender_gaps;
    int     burst_left;
    bit     hold_req;

    mixed_t got_mix;
    mixed_t want_mix;
    frame_t seen_frame;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

    // count of 0 acts as mono, above six as 5.1
    function automatic int fold_count(input count_t v);
        int c;
        c = int'(v);
        if (c < 1)
            c = 1;
        if (c > MAX_CHANNELS)
            c = MAX_CHANNELS;
        return c;
    endfunction

    // expected mixed frame for one input frame under the given layout
    function automatic mixed_t predict_mix(input frame_t f, input count_t s_reg,
                                           input count_t d_reg);
        int     s;
        int     d;
        int     n;
        bit     has_rule;
        longint gain [MAX_CHANNELS][MAX_CHANNELS];
        longint src [MAX_CHANNELS];
        longint acc;
        longint t;
        longint q;
        mixed_t r;
        s = fold_count(s_reg);
        d = fold_count(d_reg);
        n = (s < d) ? s : d;
        r = '0;
        has_rule = 1'b1;
        for (int i = 0; i < MAX_CHANNELS; i++)
            for (int j = 0; j < MAX_CHANNELS; j++)
                gain[i][j] = 0;

        // gain[dest][source] from the speaker rules
        if (s == d)
            has_rule = 1'b0;
        else if (s < d)
        begin
            if (s == 1 && (d == 2 || d == 4))
            begin
                gain[0][0] = GAIN_UNITY;
                gain[1][0] = GAIN_UNITY;
            end
            else if (s == 1 && d == 6)
                gain[2][0] = GAIN_UNITY;
            else if (s == 2 && (d == 4 || d == 6))
            begin
                gain[0][0] = GAIN_UNITY;
                gain[1][1] = GAIN_UNITY;
            end
            else if (s == 4 && d == 6)
            begin
                gain[0][0] = GAIN_UNITY;
                gain[1][1] = GAIN_UNITY;
                gain[4][2] = GAIN_UNITY;
                gain[5][3] = GAIN_UNITY;
            end
            else
                has_rule = 1'b0;
        end
        else
        begin
            if (s == 2 && d == 1)
            begin
                gain[0][0] = GAIN_HALF;
                gain[0][1] = GAIN_HALF;
            end
            else if (s == 4 && d == 1)
            begin
                for (int j = 0; j < 4; j++)
                    gain[0][j] = GAIN_QUARTER;
            end
            else if (s == 6 && d == 1)
            begin
                gain[0][0] = GAIN_RSQRT2;
                gain[0][1] = GAIN_RSQRT2;
                gain[0][2] = GAIN_UNITY;
                gain[0][4] = GAIN_HALF;
                gain[0][5] = GAIN_HALF;
            end
            else if (s == 4 && d == 2)
            begin
                gain[0][0] = GAIN_HALF;
                gain[0][2] = GAIN_HALF;
                gain[1][1] = GAIN_HALF;
                gain[1][3] = GAIN_HALF;
            end
            else if (s == 6 && d == 2)
            begin
                gain[0][0] = GAIN_UNITY;
                gain[0][2] = GAIN_RSQRT2;
                gain[0][4] = GAIN_RSQRT2;
                gain[1][1] = GAIN_UNITY;
                gain[1][2] = GAIN_RSQRT2;
                gain[1][5] = GAIN_RSQRT2;
            end
            else if (s == 6 && d == 4)
            begin
                gain[0][0] = GAIN_UNITY;
                gain[0][2] = GAIN_RSQRT2;
                gain[1][1] = GAIN_UNITY;
                gain[1][2] = GAIN_RSQRT2;
                gain[2][4] = GAIN_UNITY;
                gain[3][5] = GAIN_UNITY;
            end
            else
                has_rule = 1'b0;
        end
        // equal counts and unmatched pairs: straight sum on shared channels
        if (!has_rule)
            for (int k = 0; k < n; k++)
                gain[k][k] = GAIN_UNITY;

        for (int j = 0; j < MAX_CHANNELS; j++)
        begin
            if (j < s)
                src[j] = longint'($signed(f.src[j]));
            else
                src[j] = 0;
        end

        // exact sum, round half up, saturate; inactive channels pass acc through
        for (int i = 0; i < MAX_CHANNELS; i++)
        begin
            acc = longint'($signed(f.acc[i]));
            if (i < d)
            begin
                t = acc * GAIN_UNITY;
                for (int j = 0; j < MAX_CHANNELS; j++)
                    t += gain[i][j] * src[j];
                t += GAIN_HALF;
                q = t >>> FRAC_BITS;
                if (q > longint'(SAT_HI))
                begin
                    q = longint'(SAT_HI);
                    r.clipped = 1'b1;
                end
                else if (q < longint'(SAT_LO))
                begin
                    q = longint'(SAT_LO);
                    r.clipped = 1'b1;
                end
                r.mix[i] = q[SAMPLE_BITS-1:0];
            end
            else
                r.mix[i] = f.acc[i];
        end
        return r;
    endfunction

    // samples biased toward the rails and toward zero
    function automatic sample_t pick_sample();
        sample_t v;
        case ($urandom_range(0, 7))
            0: v = SAT_HI;
            1: v = SAT_LO;
            2: v = sample_t'(int'($urandom_range(0, 511)) - 256);
            3: v = SAT_HI - sample_t'($urandom_range(0, 4095));
            4: v = SAT_LO + sample_t'($urandom_range(0, 4095));
            default: v = sample_t'($urandom());
        endcase
        return v;
    endfunction

    function automatic frame_t random_frame();
        frame_t f;
        for (int i = 0; i < MAX_CHANNELS; i++)
        begin
            f.src[i] = pick_sample();
            f.acc[i] = pick_sample();
        end
        return f;
    endfunction

    function automatic frame_t flat_frame(input sample_t src_v, input sample_t acc_v);
        frame_t f;
        for (int i = 0; i < MAX_CHANNELS; i++)
        begin
            f.src[i] = src_v;
            f.acc[i] = acc_v;
        end
        return f;
    endfunction

    // input monitor: predict on every frame transfer
    always @(posedge clk)
    begin
        if (rst_n && frames_if.valid && !frames_if.ready)
            input_stall_cycles++;
        if (rst_n && frames_if.valid && frames_if.ready)
        begin
            seen_frame.src[0] = frames_if.src_0;
            seen_frame.src[1] = frames_if.src_1;
            seen_frame.src[2] = frames_if.src_2;
            seen_frame.src[3] = frames_if.src_3;
            seen_frame.src[4] = frames_if.src_4;
            seen_frame.src[5] = frames_if.src_5;
            seen_frame.acc[0] = frames_if.acc_0;
            seen_frame.acc[1] = frames_if.acc_1;
            seen_frame.acc[2] = frames_if.acc_2;
            seen_frame.acc[3] = frames_if.acc_3;
            seen_frame.acc[4] = frames_if.acc_4;
            seen_frame.acc[5] = frames_if.acc_5;
            expected_mixes.push_back(predict_mix(seen_frame, src_count_reg, dst_count_reg));
        end
    end

    // output checker: compare each mixed frame transfer with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && mixes_if.valid && mixes_if.ready)
        begin
            got_mix.mix[0]  = mixes_if.mix_0;
            got_mix.mix[1]  = mixes_if.mix_1;
            got_mix.mix[2]  = mixes_if.mix_2;
            got_mix.mix[3]  = mixes_if.mix_3;
            got_mix.mix[4]  = mixes_if.mix_4;
            got_mix.mix[5]  = mixes_if.mix_5;
            got_mix.clipped = mixes_if.clipped;
            if (expected_mixes.size() == 0)
            begin
                $display("%0t: mixed frame with none pending, clipped %b", $time,
                         got_mix.clipped);
                mismatch_count++;
            end
            else
            begin
                want_mix = expected_mixes.pop_front();
                frames_checked++;
                if (want_mix.clipped)
                    clipped_seen++;
                for (int i = 0; i < MAX_CHANNELS; i++)
                begin
                    if (got_mix.mix[i] !== want_mix.mix[i])
                    begin
                        $display("%0t: mix_%0d expected %0d, got %0d", $time, i,
                                 $signed(want_mix.mix[i]), $signed(got_mix.mix[i]));
                        mismatch_count++;
                    end
                end
                if (got_mix.clipped !== want_mix.clipped)
                begin
                    $display("%0t: clipped expected %b, got %b", $time,
                             want_mix.clipped, got_mix.clipped);
                    mismatch_count++;
                end
            end
        end
    end

    // receiver: changing stall patterns, plus a long hold-off on request
    initial
    begin : receiver
        int mode;
        int left;
        mixes_if.ready = 1'b0;
        mode = 0;
        left = 0;
        forever
        begin
            @(negedge clk);
            if (!rst_n)
                mixes_if.ready = 1'b0;
            else if (hold_req)
            begin
                mixes_if.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                if (left == 0)
                begin
                    mode = $urandom_range(0, 3);
                    left = $urandom_range(20, 150);
                end
                left--;
                case (mode)
                    0: mixes_if.ready = 1'b1;
                    1: mixes_if.ready = ($urandom_range(0, 3) != 0);
                    2: mixes_if.ready = ((left % 7) < 4);
                    default: mixes_if.ready = ($urandom_range(0, 9) < 3);
                endcase
            end
        end
    end

    // one frame transfer; called and returns at a falling edge
    task automatic send_frame(input frame_t f);
        frames_if.valid = 1'b1;
        frames_if.src_0 = f.src[0];
        frames_if.src_1 = f.src[1];
        frames_if.src_2 = f.src[2];
        frames_if.src_3 = f.src[3];
        frames_if.src_4 = f.src[4];
        frames_if.src_5 = f.src[5];
        frames_if.acc_0 = f.acc[0];
        frames_if.acc_1 = f.acc[1];
        frames_if.acc_2 = f.acc[2];
        frames_if.acc_3 = f.acc[3];
        frames_if.acc_4 = f.acc[4];
        frames_if.acc_5 = f.acc[5];
        do
            @(posedge clk);
        while (!frames_if.ready);
        frames_sent++;
        @(negedge clk);
        // bursts of random length with random gaps
        if (sender_gaps)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 16);
                frames_if.valid = 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge clk);
            end
            else
                burst_left--;
        end
    endtask

    // stop offering and wait for every pending mixed frame
    task automatic wait_for_results();
        frames_if.valid = 1'b0;
        while (expected_mixes.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input count_t val);
        cfg_if.valid = 1'b1;
        cfg_if.index = idx;
        cfg_if.data  = val;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        if (idx == CFG_SOURCE_CHANNELS)
            src_count_reg = val;
        else if (idx == CFG_DEST_CHANNELS)
            dst_count_reg = val;
        @(negedge clk);
        cfg_if.valid = 1'b0;
    endtask

    // registers change only with the pipeline empty
    task automatic change_layout(input count_t s, input count_t d);
        wait_for_results();
        repeat (PIPE_DEPTH) @(negedge clk);
        write_reg(CFG_SOURCE_CHANNELS, s);
        write_reg(CFG_DEST_CHANNELS, d);
        layouts_tried++;
    endtask

    // stereo to stereo right out of reset, rails and rounding
    task automatic test_reset_layout();
        send_frame(flat_frame(SAT_HI, SAT_HI));
        send_frame(flat_frame(SAT_LO, SAT_LO));
        send_frame(flat_frame(sample_t'(0), sample_t'(0)));
        send_frame(flat_frame(sample_t'(-1), SAT_HI));
    endtask

    // every up-mix and down-mix rule once
    task automatic test_speaker_rules();
        int src_list [12];
        int dst_list [12];
        src_list = '{1, 1, 1, 2, 2, 4, 2, 4, 6, 4, 6, 6};
        dst_list = '{2, 4, 6, 4, 6, 6, 1, 1, 1, 2, 2, 4};
        for (int k = 0; k < 12; k++)
        begin
            change_layout(count_t'(src_list[k]), count_t'(dst_list[k]));
            if (k % 2 == 0)
                send_frame(flat_frame(SAT_HI, sample_t'(0)));
            else
                send_frame(flat_frame(SAT_LO, SAT_LO));
        end
    endtask

    // counts of zero and seven fold into mono and 5.1
    task automatic test_count_clamp();
        change_layout(count_t'(0), count_t'(7));
        send_frame(random_frame());
        change_layout(count_t'(7), count_t'(0));
        send_frame(flat_frame(SAT_HI, SAT_HI));
    endtask

    // writes to unmapped indexes leave the layout alone; three channels sum straight
    task automatic test_unmapped_index();
        change_layout(count_t'(3), count_t'(5));
        write_reg(CFG_UNMAPPED_LO, count_t'(6));
        write_reg(CFG_UNMAPPED_HI, count_t'(1));
        send_frame(random_frame());
    endtask

    // receiver holds off long enough to fill the pipeline and stall the input
    task automatic test_backpressure();
        change_layout(count_t'(6), count_t'(2));
        sender_gaps = 1'b0;
        hold_req = 1'b1;
        repeat (24) send_frame(random_frame());
        wait_for_results();
        sender_gaps = 1'b1;
    endtask

    // random frames under every raw setting of both registers
    task automatic test_random_layouts();
        for (int s = 0; s < 8; s++)
        begin
            for (int d = 0; d < 8; d++)
            begin
                change_layout(count_t'(s), count_t'(d));
                sender_gaps = ($urandom_range(0, 3) != 0);
                burst_left = 0;
                repeat ($urandom_range(14, 30)) send_frame(random_frame());
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        frames_if.valid = 1'b0;
        frames_if.src_0 = '0;
        frames_if.src_1 = '0;
        frames_if.src_2 = '0;
        frames_if.src_3 = '0;
        frames_if.src_4 = '0;
        frames_if.src_5 = '0;
        frames_if.acc_0 = '0;
        frames_if.acc_1 = '0;
        frames_if.acc_2 = '0;
        frames_if.acc_3 = '0;
        frames_if.acc_4 = '0;
        frames_if.acc_5 = '0;
        cfg_if.valid = 1'b0;
        cfg_if.index = CFG_SOURCE_CHANNELS;
        cfg_if.data  = CNT_RESET;
        src_count_reg = CNT_RESET;
        dst_count_reg = CNT_RESET;
        mismatch_count = 0;
        frames_sent = 0;
        frames_checked = 0;
        clipped_seen = 0;
        input_stall_cycles = 0;
        layouts_tried = 0;
        sender_gaps = 1'b1;
        burst_left = 0;
        hold_req = 1'b0;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_reset_layout();
        test_speaker_rules();
        test_count_clamp();
        test_unmapped_index();
        test_backpressure();
        test_random_layouts();

        // let the pipeline empty and watch for stray frames
        wait_for_results();
        repeat (PIPE_DEPTH + 8) @(negedge clk);
        mismatch_count += expected_mixes.size();

        $display("mixed %0d frames over %0d channel-count settings, %0d with clipping",
                 frames_checked, layouts_tried, clipped_seen);
        $display("input held off for %0d cycles by output backpressure", input_stall_cycles);
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
